/* hdl/smeu_pkg.sv */
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared constants, opcodes, fault codes and stack control types for the
// stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  // sizes; program depth and register count are powers of two
  localparam int PROGRAM_DEPTH = 4096;
  localparam int STACK_DEPTH   = 64;
  localparam int REG_COUNT     = 256;

  localparam int PC_W   = $clog2(PROGRAM_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int RIDX_W = $clog2(REG_COUNT);

  // fixed field widths
  localparam int TYPE_W   = 4;
  localparam int IMM_W    = 32;
  localparam int TGT_W    = 12;
  localparam int RIN_W    = 8;
  localparam int IP_W     = 12;
  localparam int DATA_W   = 64;
  localparam int FAULT_W  = 2;

  // call saves the return address here
  localparam int LINK_REG = 1;

  typedef enum logic [TYPE_W-1:0] {
    OP_PRINT = 4'd0,
    OP_PUSH  = 4'd1,
    OP_POP   = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_JMP   = 4'd5,
    OP_DUP   = 4'd6,
    OP_REGST = 4'd7,
    OP_REGLD = 4'd8,
    OP_CALL  = 4'd9,
    OP_RET   = 4'd10,
    OP_JZ    = 4'd11,
    OP_EXIT  = 4'd12,
    OP_START = 4'd13
  } op_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK     = 2'd0,
    FAULT_UNDER  = 2'd1,
    FAULT_OVER   = 2'd2,
    FAULT_HALTED = 2'd3
  } fault_e;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,  // keep own value
    SH_DOWN = 2'd1,  // take neighbor nearer the top (or new top value)
    SH_UP   = 2'd2   // take neighbor nearer the bottom
  } shift_e;

  typedef struct packed {
    shift_e top_shift;   // applies to the top cell
    shift_e rest_shift;  // applies to every other cell
  } stack_ctrl_t;

endpackage

/* hdl/stack_machine_execute_unit.sv */
// Path: an input transfer loads the issue stage register; execute then loads the result register.
// Throughput: one instruction per cycle while the result output is not stalled; the single
// execute stage shifts the operand stack cell chain and updates counter and flags together.
// Register file reads start at the input transfer, writes are forwarded to the next item.
// Reset: stack count and program counter cleared, running set; stack and registers
// hold no defined value until written.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Two-stage interpreter: register read at transfer, then execute against a
// chain of stack cells, with a registered result.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [smeu_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [smeu_pkg::IMM_W-1:0]   push_value_i,
  input  logic [smeu_pkg::TGT_W-1:0]   target_i,
  input  logic [smeu_pkg::RIN_W-1:0]   reg_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [smeu_pkg::IP_W-1:0]    next_ip_o,
  output logic [smeu_pkg::DATA_W-1:0]  top_value_o,
  output logic                         print_valid_o,
  output logic                         halted_o,
  output logic [smeu_pkg::FAULT_W-1:0] fault_o
);
  import smeu_pkg::*;

  // handshake
  logic in_fire, exec_fire;

  // issue stage
  logic                a_valid_q, a_valid_d;
  logic [TYPE_W-1:0]   a_type_q;
  logic [IMM_W-1:0]    a_imm_q;
  logic [TGT_W-1:0]    a_tgt_q;
  logic [RIN_W-1:0]    a_ridx_q;
  logic                fwd_hit_q;
  logic [DATA_W-1:0]   fwd_data_q;
  logic [DATA_W-1:0]   rf_rd_data;
  logic [DATA_W-1:0]   reg_value;

  // architectural state
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic                run_q, run_d;

  // stack chain
  stack_ctrl_t         ctrl;
  logic [DATA_W-1:0]   top_in;
  logic [DATA_W-1:0]   cell_q    [STACK_DEPTH];
  logic [DATA_W-1:0]   cell_next [STACK_DEPTH];

  // register file write
  logic                wr_en;
  logic [RIDX_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;

  // execute
  op_e                 op;
  logic [PC_W-1:0]     adv, tgt;
  logic [RIDX_W-1:0]   ri;
  logic [1:0]          need;
  logic                grow;
  logic [DATA_W-1:0]   t;
  logic [IMM_W-1:0]    arg_a, arg_b, alu_res;
  fault_e              fault;
  logic                pv;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [IP_W-1:0]     ip_q;
  logic [DATA_W-1:0]   top_q;
  logic                pv_q;
  logic                halted_q;
  logic [FAULT_W-1:0]  fault_q;

  assign exec_fire  = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !exec_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign a_valid_d  = in_fire || (a_valid_q && !exec_fire);

  // issue stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      if (in_fire) begin
        fwd_hit_q <= exec_fire && wr_en && (wr_addr == RIDX_W'(reg_index_i));
      end
    end
  end

  // issue stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_type_q   <= req_type_i;
      a_imm_q    <= push_value_i;
      a_tgt_q    <= target_i;
      a_ridx_q   <= reg_index_i;
      fwd_data_q <= wr_data;
    end
  end

  smeu_regfile u_regfile (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (in_fire),
    .rd_addr_i (RIDX_W'(reg_index_i)),
    .rd_data_o (rf_rd_data)
  );

  // a write at the transfer edge is missed by the read, take it here
  assign reg_value = fwd_hit_q ? fwd_data_q : rf_rd_data;

  // stack cell chain, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above, below;
    if (i == 0) begin : g_first
      assign above = top_in;
    end else begin : g_inner
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid
      assign below = cell_q[i+1];
    end
    smeu_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .is_top_i (i == 0),
      .above_i  (above),
      .below_i  (below),
      .data_o   (cell_q[i]),
      .next_o   (cell_next[i])
    );
  end

  assign op      = op_e'(a_type_q);
  assign adv     = pc_q + PC_W'(1);
  assign tgt     = PC_W'(a_tgt_q);
  assign ri      = RIDX_W'(a_ridx_q);
  assign t       = cell_q[0];
  assign arg_a   = t[IMM_W-1:0];
  assign arg_b   = cell_q[1][IMM_W-1:0];
  assign alu_res = (op == OP_ADD) ? (arg_a + arg_b) : IMM_W'(arg_a * arg_b);

  // stack demand per operation
  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    unique case (op)
      OP_PRINT, OP_POP, OP_REGST, OP_RET, OP_JZ: need = 2'd1;
      OP_ADD, OP_MUL:                            need = 2'd2;
      OP_DUP: begin
        need = 2'd1;
        grow = 1'b1;
      end
      OP_PUSH, OP_REGLD:                         grow = 1'b1;
      default: ;
    endcase
  end

  // execute
  always_comb begin
    pc_d            = pc_q;
    run_d           = run_q;
    cnt_d           = cnt_q;
    ctrl.top_shift  = SH_HOLD;
    ctrl.rest_shift = SH_HOLD;
    top_in          = '0;
    wr_en           = 1'b0;
    wr_addr         = ri;
    wr_data         = t;
    pv              = 1'b0;
    fault           = FAULT_OK;
    if (!run_q && op != OP_START) begin
      fault = FAULT_HALTED;
    end else if (op == OP_START) begin
      pc_d  = tgt;
      run_d = 1'b1;
    end else begin
      pc_d = adv;
      if (cnt_q < CNT_W'(need)) begin
        fault = FAULT_UNDER;
      end else if (grow && cnt_q >= CNT_W'(STACK_DEPTH)) begin
        fault = FAULT_OVER;
      end else begin
        unique case (op)
          OP_PRINT: pv = 1'b1;
          OP_PUSH: begin
            top_in          = DATA_W'(a_imm_q);
            ctrl.top_shift  = SH_DOWN;
            ctrl.rest_shift = SH_DOWN;
            cnt_d           = cnt_q + CNT_W'(1);
          end
          OP_POP: begin
            ctrl.top_shift  = SH_UP;
            ctrl.rest_shift = SH_UP;
            cnt_d           = cnt_q - CNT_W'(1);
          end
          OP_ADD, OP_MUL: begin
            top_in          = DATA_W'(alu_res);
            ctrl.top_shift  = SH_DOWN;
            ctrl.rest_shift = SH_UP;
            cnt_d           = cnt_q - CNT_W'(1);
          end
          OP_JMP: pc_d = tgt;
          OP_DUP: begin
            ctrl.rest_shift = SH_DOWN;
            cnt_d           = cnt_q + CNT_W'(1);
          end
          OP_REGST: wr_en = 1'b1;
          OP_REGLD: begin
            top_in          = reg_value;
            ctrl.top_shift  = SH_DOWN;
            ctrl.rest_shift = SH_DOWN;
            cnt_d           = cnt_q + CNT_W'(1);
          end
          OP_CALL: begin
            wr_en   = 1'b1;
            wr_addr = RIDX_W'(LINK_REG);
            wr_data = DATA_W'(adv);
            pc_d    = tgt;
          end
          OP_RET: begin
            ctrl.top_shift  = SH_UP;
            ctrl.rest_shift = SH_UP;
            cnt_d           = cnt_q - CNT_W'(1);
            pc_d            = t[PC_W-1:0];
          end
          OP_JZ: begin
            if (t == '0) begin
              pc_d = tgt;
            end
          end
          OP_EXIT: run_d = 1'b0;
          default: ;
        endcase
      end
    end
    // only a firing item changes anything
    if (!exec_fire) begin
      ctrl.top_shift  = SH_HOLD;
      ctrl.rest_shift = SH_HOLD;
      wr_en           = 1'b0;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pc_q  <= '0;
      run_q <= 1'b1;
    end else if (exec_fire) begin
      cnt_q <= cnt_d;
      pc_q  <= pc_d;
      run_q <= run_d;
    end
  end

  // result register control
  always_comb begin
    priority if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      ip_q     <= IP_W'(pc_d);
      top_q    <= (cnt_d == '0) ? '0 : cell_next[0];
      pv_q     <= pv;
      halted_q <= !run_d;
      fault_q  <= fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_ip_o     = ip_q;
  assign top_value_o   = top_q;
  assign print_valid_o = pv_q;
  assign halted_o      = halted_q;
  assign fault_o       = fault_q;

endmodule

/* hdl/smeu_cell.sv */
// ----------------------------------------------------------------------------
// smeu_cell
// One operand stack entry; loads from a neighbor or holds, as told.
// ----------------------------------------------------------------------------
module smeu_cell (
  input  logic                       clk_i,
  input  smeu_pkg::stack_ctrl_t      ctrl_i,
  input  logic                       is_top_i,
  input  logic [smeu_pkg::DATA_W-1:0] above_i,
  input  logic [smeu_pkg::DATA_W-1:0] below_i,
  output logic [smeu_pkg::DATA_W-1:0] data_o,
  output logic [smeu_pkg::DATA_W-1:0] next_o
);
  import smeu_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  shift_e            shift;

  // top cell has its own control
  assign shift = is_top_i ? ctrl_i.top_shift : ctrl_i.rest_shift;

  // neighbor select
  always_comb begin
    unique case (shift)
      SH_HOLD: data_d = data_q;
      SH_DOWN: data_d = above_i;
      SH_UP:   data_d = below_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

/* hdl/smeu_regfile.sv */
// ----------------------------------------------------------------------------
// smeu_regfile
// General register file, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module smeu_regfile (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [smeu_pkg::RIDX_W-1:0] wr_addr_i,
  input  logic [smeu_pkg::DATA_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [smeu_pkg::RIDX_W-1:0] rd_addr_i,
  output logic [smeu_pkg::DATA_W-1:0] rd_data_o
);
  import smeu_pkg::*;

  logic [DATA_W-1:0] mem_q [REG_COUNT];
  logic [DATA_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/smeu_checker.sv */
// ----------------------------------------------------------------------------
// smeu_checker
// Port-level checks on the input and result channels of the execute unit.
// ----------------------------------------------------------------------------
module smeu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [smeu_pkg::TYPE_W-1:0]  req_type_i,
  input logic [smeu_pkg::IMM_W-1:0]   push_value_i,
  input logic [smeu_pkg::TGT_W-1:0]   target_i,
  input logic [smeu_pkg::RIN_W-1:0]   reg_index_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [smeu_pkg::IP_W-1:0]    next_ip_o,
  input logic [smeu_pkg::DATA_W-1:0]  top_value_o,
  input logic                         print_valid_o,
  input logic                         halted_o,
  input logic [smeu_pkg::FAULT_W-1:0] fault_o
);
  import smeu_pkg::*;

  // a stalled instruction holds until its transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(req_type_i)
      && $stable(push_value_i) && $stable(target_i) && $stable(reg_index_i))
    else $error("instruction changed while stalled");

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_ip_o)
      && $stable(top_value_o) && $stable(print_valid_o) && $stable(fault_o))
    else $error("result changed while stalled");

  // a print only comes from a running machine without fault
  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && print_valid_o |-> fault_o == FAULT_OK && !halted_o)
    else $error("print with fault or halted");

  // an ignored instruction leaves the machine halted
  a_halted_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o == FAULT_HALTED |-> halted_o)
    else $error("halted fault while running");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (.*);
